@@ rtl/klt_pkg.sv @@
`default_nettype none

package klt_pkg;

  // Item kinds carried in the slave-side tuser.
  localparam logic [1:0] OP_KEY    = 2'd0;
  localparam logic [1:0] OP_LAYOUT = 2'd1;
  localparam logic [1:0] OP_PLANE  = 2'd2;
  localparam logic [1:0] OP_DIA    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_PLANES = 2'd1;
  localparam logic [1:0] REG_LOCK   = 2'd2;
  localparam logic [1:0] REG_DEADS  = 2'd3;

  // Command code ranges found in layout entries.
  localparam logic [7:0] DEAD_LO = 8'd200;
  localparam logic [7:0] DEAD_HI = 8'd235;
  localparam logic [7:0] SW_LO   = 8'd120;
  localparam logic [7:0] SW_HI   = 8'd140;
  localparam logic [7:0] SW_BASE = 8'd119;
  localparam logic [7:0] UOFF_LO = 8'd180;
  localparam logic [7:0] UON_LO  = 8'd188;
  localparam logic [7:0] UON_HI  = 8'd196;
  localparam logic [7:0] NOP_CMD = 8'd160;

  // Flag bits.
  localparam logic [6:0] LOCK_FILTER = 7'h7c;

  typedef enum logic [2:0] {
    CLS_DEAD   = 3'd0,
    CLS_SWITCH = 3'd1,
    CLS_UOFF   = 3'd2,
    CLS_UON    = 3'd3,
    CLS_NOP    = 3'd4,
    CLS_OTHER  = 3'd5
  } cmd_cls_e;

  typedef enum logic [4:0] {
    DP_NONE     = 5'd0,
    DP_CLEAR    = 5'd1,
    DP_ACCEPT   = 5'd2,
    DP_RD_KF    = 5'd3,
    DP_RD_CB    = 5'd4,
    DP_RD_NS    = 5'd5,
    DP_LAT_E    = 5'd6,
    DP_PLANE_RD = 5'd7,
    DP_PNEXT    = 5'd8,
    DP_EXEC     = 5'd9,
    DP_EMIT_E   = 5'd10,
    DP_WALK_INIT= 5'd11,
    DP_WALK_RD  = 5'd12,
    DP_WALK_ADD = 5'd13,
    DP_DRD_S1   = 5'd14,
    DP_LEN      = 5'd15,
    DP_DEF      = 5'd16,
    DP_SRD      = 5'd17,
    DP_SNEXT    = 5'd18,
    DP_HRD      = 5'd19,
    DP_EMIT_VAL = 5'd20,
    DP_EMIT_DEF = 5'd21,
    DP_DRD_S    = 5'd22,
    DP_DROP     = 5'd23,
    DP_LOAD     = 5'd24
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   set_hand;
  } klt_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] op_kind;
    logic       key_bad;
    logic       norm_ok;
    logic       e_zero;
    logic       is_cmd;
    cmd_cls_e   cls;
    logic       plane_done;
    logic       plane_match;
    logic       pend_nz;
    logic       pend_ok;
    logic       walk_done;
    logic       srch_done;
    logic       hit;
    logic       key_mod;
    logic       out_busy;
  } klt_stat_t;

endpackage

`default_nettype wire

@@ rtl/keyboard_layout_translator_top.sv @@
// Keyboard layout translator.
//
// The slave stream takes one item per handshake. tuser selects the kind: a key
// event, or a write into the layout table, the plane descriptors or the
// diacritics store. Writes complete in the cycle they are accepted and give no
// result. A key event gives one result item, or two when a pending dead key's
// default character precedes the remapped key; tlast marks the final one.
// Configuration registers are written through cfg_we_i/cfg_index_i/cfg_data_i
// and should only be changed while the block is idle.
// A key event that is out of range or arrives with the layout off skips the lookups.
// Any other goes through the lookups, then the extra planes examined, the dead-key
// subtables skipped and the diacritic pairs compared, all on one read port of
// each RAM, so a single item is in flight at a time.
// Results sit in an output register, so a stalled master side does not stop the next
// item from being accepted and worked on; only its hand-over waits for the last results.
// After reset the layout table is cleared, one word per cycle, all
// (MAX_SCAN+1)*PAGES_PER_KEY words (1068 by default); s_axis_tready stays low
// meanwhile. Plane descriptors, the pending dead key and the user keys reset
// at once; the diacritics store holds no defined value until written.
`default_nettype none

module keyboard_layout_translator_top
  import klt_pkg::*;
#(
  parameter int MAX_SCAN        = 88,
  parameter int PAGES_PER_KEY   = 12,
  parameter int DIACRITIC_BYTES = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [6:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: scan_code[7:0], shift_flags[15:8], shift_flags_ext[23:16],
  // kbd_status_flags[31:24], write_index[42:32], write_data[58:43], zero above.
  input  wire logic [63:0] s_axis_tdata,
  // tuser: operation[1:0].
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: handled[0], key_valid[1], key_word[17:2], switch_valid[18],
  // submap_number[23:19].
  output logic [23:0]      m_axis_tdata,
  output logic             m_axis_tlast
);

  klt_cmd_t  cmd;
  klt_stat_t stat;

  klt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  klt_dp #(
    .MaxScan        (MAX_SCAN),
    .PagesPerKey    (PAGES_PER_KEY),
    .DiacriticBytes (DIACRITIC_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_op_i     (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ rtl/klt_ram.sv @@
`default_nettype none

module klt_ram #(
  parameter int Width = 16,
  parameter int Depth = 1068
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/klt_ctrl.sv @@
`default_nettype none

module klt_ctrl
  import klt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire klt_stat_t stat_i,
  output klt_cmd_t       cmd_o
);

  typedef enum logic [19:0] {
    S_CLEAR = 20'h00001,
    S_IDLE  = 20'h00002,
    S_CHECK = 20'h00004,
    S_KF    = 20'h00008,
    S_CB    = 20'h00010,
    S_NE    = 20'h00020,
    S_PLANE = 20'h00040,
    S_PE    = 20'h00080,
    S_MAP   = 20'h00100,
    S_WALK  = 20'h00200,
    S_WALKW = 20'h00400,
    S_LEN   = 20'h00800,
    S_DEF   = 20'h01000,
    S_SRCH  = 20'h02000,
    S_CMP   = 20'h04000,
    S_HIT   = 20'h08000,
    S_EMITE = 20'h10000,
    S_FVAL  = 20'h20000,
    S_FINAL = 20'h40000,
    S_DONE  = 20'h80000
  } state_e;

  state_e state_q, state_d;
  logic   plane_ph_q, plane_ph_d;   // searching extra planes rather than normal/shift
  logic   ctx_fin_q, ctx_fin_d;     // subtable walk serves the fall-through path

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    plane_ph_d = plane_ph_q;
    ctx_fin_d  = ctx_fin_q;
    cmd_o      = '{op: DP_NONE, set_hand: 1'b0};
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = DP_CLEAR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_ACCEPT;
          if (stat_i.op_kind == OP_KEY) state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        plane_ph_d = 1'b0;
        if (stat_i.key_bad) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = DP_RD_KF;
          state_d  = S_KF;
        end
      end
      S_KF: begin
        cmd_o.op = DP_RD_CB;
        state_d  = S_CB;
      end
      S_CB: begin
        cmd_o.op = DP_RD_NS;
        if (stat_i.norm_ok) begin
          state_d = S_NE;
        end else begin
          plane_ph_d = 1'b1;
          state_d    = S_PLANE;
        end
      end
      S_NE: begin
        cmd_o.op = DP_LAT_E;
        if (stat_i.e_zero) begin
          plane_ph_d = 1'b1;
          state_d    = S_PLANE;
        end else begin
          state_d = S_MAP;
        end
      end
      S_PLANE: begin
        plane_ph_d = 1'b1;
        if (stat_i.plane_done) begin
          state_d = S_FINAL;
        end else if (stat_i.plane_match) begin
          cmd_o.op = DP_PLANE_RD;
          state_d  = S_PE;
        end else begin
          cmd_o.op = DP_PNEXT;
        end
      end
      S_PE: begin
        cmd_o.op = DP_LAT_E;
        state_d  = stat_i.e_zero ? S_FINAL : S_MAP;
      end
      S_MAP: begin
        if (stat_i.is_cmd) begin
          if (stat_i.cls == CLS_OTHER) begin
            if (plane_ph_q) cmd_o.op = DP_PNEXT;
            state_d = S_PLANE;
          end else begin
            cmd_o = '{op: DP_EXEC, set_hand: 1'b1};
            state_d = S_DONE;
          end
        end else if (stat_i.pend_nz && stat_i.pend_ok) begin
          cmd_o     = '{op: DP_WALK_INIT, set_hand: 1'b1};
          ctx_fin_d = 1'b0;
          state_d   = S_WALK;
        end else begin
          cmd_o   = '{op: DP_EMIT_E, set_hand: 1'b1};
          state_d = S_DONE;
        end
      end
      S_WALK: begin
        if (stat_i.walk_done) begin
          if (ctx_fin_q) begin
            cmd_o.op = DP_DRD_S;
            state_d  = S_FVAL;
          end else begin
            cmd_o.op = DP_DRD_S1;
            state_d  = S_LEN;
          end
        end else begin
          cmd_o.op = DP_WALK_RD;
          state_d  = S_WALKW;
        end
      end
      S_WALKW: begin
        cmd_o.op = DP_WALK_ADD;
        state_d  = S_WALK;
      end
      S_LEN: begin
        cmd_o.op = DP_LEN;
        state_d  = S_DEF;
      end
      S_DEF: begin
        cmd_o.op = DP_DEF;
        state_d  = S_SRCH;
      end
      S_SRCH: begin
        if (stat_i.srch_done) begin
          cmd_o.op = DP_EMIT_DEF;
          state_d  = S_EMITE;
        end else begin
          cmd_o.op = DP_SRD;
          state_d  = S_CMP;
        end
      end
      S_CMP: begin
        if (stat_i.hit) begin
          cmd_o.op = DP_HRD;
          state_d  = S_HIT;
        end else begin
          cmd_o.op = DP_SNEXT;
          state_d  = S_SRCH;
        end
      end
      S_HIT: begin
        cmd_o.op = DP_EMIT_VAL;
        state_d  = S_DONE;
      end
      S_EMITE: begin
        cmd_o.op = DP_EMIT_E;
        state_d  = S_DONE;
      end
      S_FVAL: begin
        cmd_o.op = DP_EMIT_VAL;
        state_d  = S_DONE;
      end
      S_FINAL: begin
        if (stat_i.pend_nz && !stat_i.key_mod) begin
          if (!stat_i.pend_ok) begin
            cmd_o   = '{op: DP_DROP, set_hand: 1'b1};
            state_d = S_DONE;
          end else begin
            cmd_o.op  = DP_WALK_INIT;
            ctx_fin_d = 1'b1;
            state_d   = S_WALK;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      plane_ph_q <= 1'b0;
      ctx_fin_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      plane_ph_q <= plane_ph_d;
      ctx_fin_q  <= ctx_fin_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/klt_dp.sv @@
`default_nettype none

module klt_dp
  import klt_pkg::*;
#(
  parameter int MaxScan        = 88,
  parameter int PagesPerKey    = 12,
  parameter int DiacriticBytes = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [6:0]  cfg_data_i,
  input  wire logic [1:0]  in_op_i,
  input  wire logic [63:0] in_data_i,
  input  wire klt_cmd_t    cmd_i,
  output klt_stat_t        stat_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [23:0]      out_data_o,
  output logic             out_last_o
);

  localparam int Extra      = PagesPerKey - 4;
  localparam int LayWords   = (MaxScan + 1) * PagesPerKey;
  localparam int PlaneWords = Extra * 4;
  localparam int LA         = $clog2(LayWords);
  localparam int PIW        = $clog2(PlaneWords);
  localparam int PW         = $clog2(Extra + 1);
  localparam int PGW        = $clog2(PagesPerKey);
  localparam int DW         = $clog2(DiacriticBytes);

  localparam logic [7:0] SC_CTRL   = 8'h1d;
  localparam logic [7:0] SC_LSHIFT = 8'h2a;
  localparam logic [7:0] SC_RSHIFT = 8'h36;
  localparam logic [7:0] SC_ALT    = 8'h38;
  localparam logic [7:0] SC_CAPS   = 8'h3a;
  localparam logic [7:0] SC_NUM    = 8'h45;
  localparam logic [7:0] SC_SCROLL = 8'h46;

  // Input fields.
  logic [7:0]  in_scan, in_f1, in_f2, in_f3;
  logic [10:0] in_widx;
  logic [15:0] in_wdat;
  assign in_scan = in_data_i[7:0];
  assign in_f1   = in_data_i[15:8];
  assign in_f2   = in_data_i[23:16];
  assign in_f3   = in_data_i[31:24];
  assign in_widx = in_data_i[42:32];
  assign in_wdat = in_data_i[58:43];

  // Configuration.
  logic       en_q;
  logic [3:0] pc_q;
  logic [6:0] lock_q;
  logic [5:0] dkc_q;

  // Item state.
  logic [7:0]             key_q, f1_q, f2_q, f3_q;
  logic [LA-1:0]          base_q;
  logic                   caps_q, pair_q;
  logic [PagesPerKey-1:0] cbits_q;
  logic [PGW-1:0]         pg_q;
  logic [PW-1:0]          p_q;
  logic [15:0]            entry_q;
  logic [7:0]             pend_q, ukb_q;
  logic [15:0]            s_q, ptr_q;
  logic [5:0]             i_q, n_q;
  logic [7:0]             len_q, j_q, def_q;
  logic                   hand_q, sw_q;
  logic [4:0]             num_q;
  logic [1:0]             wcnt_q;
  logic [15:0]            w0_q, w1_q;
  logic [LA-1:0]          clr_q;
  logic [15:0]            plane_q [PlaneWords];
  logic                   oob_q;

  // Output stage.
  logic        ob_valid_q, ob_idx_q, ob_two_q, ob_hand_q, ob_sw_q;
  logic [1:0]  ob_cnt_q;
  logic [4:0]  ob_num_q;
  logic [15:0] ob_w0_q, ob_w1_q;

  // Memories.
  logic          lay_we;
  logic [LA-1:0] lay_waddr, lay_raddr;
  logic [15:0]   lay_wdata, lay_rdata;
  logic          dia_we;
  logic [15:0]   dia_raddr;
  logic [7:0]    dia_rdata, dia_val;

  klt_ram #(.Width(16), .Depth(LayWords)) u_layout (
    .clk_i   (clk_i),
    .we_i    (lay_we),
    .waddr_i (lay_waddr),
    .wdata_i (lay_wdata),
    .raddr_i (lay_raddr),
    .rdata_o (lay_rdata)
  );

  klt_ram #(.Width(8), .Depth(DiacriticBytes)) u_dia (
    .clk_i   (clk_i),
    .we_i    (dia_we),
    .waddr_i (in_widx[DW-1:0]),
    .wdata_i (in_wdat[7:0]),
    .raddr_i (dia_raddr[DW-1:0]),
    .rdata_o (dia_rdata)
  );

  assign dia_val = oob_q ? 8'd0 : dia_rdata;

  logic accept;
  assign accept = (cmd_i.op == DP_ACCEPT);

  always_comb begin
    lay_we    = 1'b0;
    lay_waddr = in_widx[LA-1:0];
    lay_wdata = in_wdat;
    if (cmd_i.op == DP_CLEAR) begin
      lay_we    = 1'b1;
      lay_waddr = clr_q;
      lay_wdata = 16'd0;
    end else if (accept && in_op_i == OP_LAYOUT && 32'(in_widx) < LayWords) begin
      lay_we = 1'b1;
    end
  end

  assign dia_we = accept && in_op_i == OP_DIA && 32'(in_widx) < DiacriticBytes;

  // Normal or shift page selection.
  logic sh;
  assign sh = (f1_q[1] | f1_q[0]) ^ (caps_q & f1_q[6]);

  always_comb begin
    case (cmd_i.op)
      DP_RD_KF:    lay_raddr = base_q + LA'(PagesPerKey - 1);
      DP_RD_CB:    lay_raddr = base_q + LA'(PagesPerKey - 2);
      DP_RD_NS:    lay_raddr = base_q + LA'(sh);
      default:     lay_raddr = base_q + LA'(p_q) + LA'(2);
    endcase
  end

  always_comb begin
    case (cmd_i.op)
      DP_SRD:  dia_raddr = ptr_q;
      DP_HRD:  dia_raddr = ptr_q + 16'd1;
      DP_LEN,
      DP_DRD_S: dia_raddr = s_q;
      default: dia_raddr = s_q + 16'd1;
    endcase
  end

  // Flag word matched against the plane masks.
  logic [15:0] cur;
  assign cur = {1'b0, f1_q[1] | f1_q[0], 1'b0, f3_q[1], f3_q[3:2], f2_q[1:0],
                1'b0, f1_q[6:0]};

  logic [PIW-1:0] pidx;
  logic [15:0]    req, forb, ureq, uforb;
  logic [4:0]     np;
  assign pidx  = PIW'({p_q, 2'b00});
  assign req   = plane_q[pidx];
  assign forb  = plane_q[pidx + PIW'(1)];
  assign ureq  = plane_q[pidx + PIW'(2)];
  assign uforb = plane_q[pidx + PIW'(3)];
  assign np    = (5'(pc_q) > 5'(Extra)) ? 5'(Extra) : 5'(pc_q);

  logic [7:0] code;
  cmd_cls_e   cls;
  assign code = entry_q[7:0];
  always_comb begin
    if (code >= DEAD_LO && code < DEAD_HI)     cls = CLS_DEAD;
    else if (code >= SW_LO && code < SW_HI)    cls = CLS_SWITCH;
    else if (code >= UOFF_LO && code < UON_LO) cls = CLS_UOFF;
    else if (code >= UON_LO && code < UON_HI)  cls = CLS_UON;
    else if (code == NOP_CMD)                  cls = CLS_NOP;
    else                                       cls = CLS_OTHER;
  end

  logic key_mod;
  always_comb begin
    case (key_q)
      SC_CTRL, SC_LSHIFT, SC_RSHIFT, SC_ALT, SC_CAPS, SC_NUM, SC_SCROLL: key_mod = 1'b1;
      default: key_mod = 1'b0;
    endcase
  end

  logic [15:0] emit_word;
  logic        do_emit;
  always_comb begin
    do_emit   = 1'b1;
    emit_word = {key_q, dia_val};
    case (cmd_i.op)
      DP_EMIT_E:   emit_word = pair_q ? entry_q : {key_q, entry_q[7:0]};
      DP_EMIT_DEF: emit_word = {key_q, def_q};
      DP_EMIT_VAL: emit_word = {key_q, dia_val};
      default:     do_emit = 1'b0;
    endcase
  end

  always_comb begin
    stat_o.clr_last    = (32'(clr_q) == LayWords - 1);
    stat_o.op_kind     = in_op_i;
    stat_o.key_bad     = (32'(key_q) > MaxScan) || !en_q;
    stat_o.norm_ok     = ((f1_q[6:0] & lock_q & LOCK_FILTER) == 7'd0) && !f3_q[1];
    stat_o.e_zero      = (lay_rdata == 16'd0);
    stat_o.is_cmd      = cbits_q[pg_q];
    stat_o.cls         = cls;
    stat_o.plane_done  = (5'(p_q) >= np);
    stat_o.plane_match = ((cur & req) == req) && (({8'd0, ukb_q} & ureq) == ureq) &&
                         ((cur & forb) == 16'd0) && (({8'd0, ukb_q} & uforb) == 16'd0);
    stat_o.pend_nz     = (pend_q != 8'd0);
    stat_o.pend_ok     = (pend_q >= DEAD_LO) && (8'(pend_q - DEAD_LO) < {2'b00, dkc_q});
    stat_o.walk_done   = (i_q == n_q);
    stat_o.srch_done   = (j_q == len_q);
    stat_o.hit         = (dia_val == entry_q[7:0]);
    stat_o.key_mod     = key_mod;
    stat_o.out_busy    = ob_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      pc_q   <= 4'd0;
      lock_q <= 7'd15;
      dkc_q  <= 6'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ENABLE: en_q   <= cfg_data_i[0];
        REG_PLANES: pc_q   <= cfg_data_i[3:0];
        REG_LOCK:   lock_q <= cfg_data_i;
        REG_DEADS:  dkc_q  <= cfg_data_i[5:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PlaneWords; k++) begin
        plane_q[k] <= (k % 2 == 1) ? 16'hffff : 16'h0000;
      end
      pend_q <= 8'd0;
      ukb_q  <= 8'd0;
      clr_q  <= '0;
      hand_q <= 1'b0;
      sw_q   <= 1'b0;
      num_q  <= 5'd0;
      wcnt_q <= 2'd0;
      p_q    <= '0;
      pg_q   <= '0;
      oob_q  <= 1'b0;
    end else begin
      oob_q <= (32'(dia_raddr) >= DiacriticBytes);
      if (cmd_i.set_hand) hand_q <= 1'b1;
      if (do_emit) begin
        if (wcnt_q == 2'd0) w0_q <= emit_word;
        else                w1_q <= emit_word;
        if (wcnt_q != 2'd2) wcnt_q <= wcnt_q + 2'd1;
      end
      case (cmd_i.op)
        DP_CLEAR: clr_q <= clr_q + LA'(1);
        DP_ACCEPT: begin
          key_q  <= in_scan;
          f1_q   <= in_f1;
          f2_q   <= in_f2;
          f3_q   <= in_f3;
          base_q <= LA'(32'(in_scan) * PagesPerKey);
          hand_q <= 1'b0;
          sw_q   <= 1'b0;
          num_q  <= 5'd0;
          wcnt_q <= 2'd0;
          if (in_op_i == OP_PLANE && 32'(in_widx) < PlaneWords) begin
            plane_q[in_widx[PIW-1:0]] <= in_wdat;
          end
        end
        DP_RD_CB: begin
          caps_q <= lay_rdata[6];
          pair_q <= lay_rdata[7];
        end
        DP_RD_NS: begin
          cbits_q <= lay_rdata[PagesPerKey-1:0];
          pg_q    <= PGW'(sh);
          p_q     <= '0;
        end
        DP_LAT_E:    entry_q <= lay_rdata;
        DP_PLANE_RD: pg_q <= PGW'(p_q) + PGW'(2);
        DP_PNEXT:    p_q <= p_q + PW'(1);
        DP_EXEC: begin
          case (cls)
            CLS_DEAD: begin
              if ({1'b0, code} >= (9'(dkc_q) + 9'(DEAD_LO))) pend_q <= 8'd0;
              else                                          pend_q <= code;
            end
            CLS_SWITCH: begin
              sw_q  <= 1'b1;
              num_q <= 5'(code - SW_BASE);
            end
            CLS_UOFF: ukb_q <= ukb_q & ~(8'd1 << 3'(code - UOFF_LO));
            CLS_UON:  ukb_q <= ukb_q | (8'd1 << 3'(code - UON_LO));
            default:  ;
          endcase
        end
        DP_EMIT_E: pend_q <= 8'd0;
        DP_DROP:   pend_q <= 8'd0;
        DP_WALK_INIT: begin
          n_q    <= 6'(pend_q - DEAD_LO);
          i_q    <= 6'd0;
          s_q    <= 16'd0;
          pend_q <= 8'd0;
        end
        DP_WALK_ADD: begin
          s_q <= s_q + {7'd0, dia_val, 1'b0} + 16'd2;
          i_q <= i_q + 6'd1;
        end
        DP_LEN: len_q <= dia_val;
        DP_DEF: begin
          def_q <= dia_val;
          ptr_q <= s_q + 16'd2;
          j_q   <= 8'd0;
        end
        DP_SNEXT: begin
          ptr_q <= ptr_q + 16'd2;
          j_q   <= j_q + 8'd1;
        end
        default: ;
      endcase
    end
  end

  // Output stage: holds a finished item's results while the next item is worked on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_valid_q <= 1'b0;
      ob_idx_q   <= 1'b0;
    end else if (cmd_i.op == DP_LOAD) begin
      ob_valid_q <= 1'b1;
      ob_idx_q   <= 1'b0;
      ob_two_q   <= (wcnt_q == 2'd2);
      ob_cnt_q   <= wcnt_q;
      ob_hand_q  <= hand_q;
      ob_sw_q    <= sw_q;
      ob_num_q   <= num_q;
      ob_w0_q    <= w0_q;
      ob_w1_q    <= w1_q;
    end else if (ob_valid_q && out_ready_i) begin
      if (out_last_o) ob_valid_q <= 1'b0;
      else            ob_idx_q   <= 1'b1;
    end
  end

  logic        kv;
  logic [15:0] kw;
  assign kv = ({1'b0, ob_idx_q} < ob_cnt_q);
  assign kw = !kv ? 16'd0 : (ob_idx_q ? ob_w1_q : ob_w0_q);

  assign out_valid_o = ob_valid_q;
  assign out_last_o  = ob_two_q ? ob_idx_q : 1'b1;
  assign out_data_o  = {ob_sw_q ? ob_num_q : 5'd0, ob_sw_q, kw, kv, ob_hand_q};

endmodule

`default_nettype wire

@@ rtl/klt_checker.sv @@
`default_nettype none

module klt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // No result is offered while reset is held.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result offered during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // A result without a key word carries a zero word.
  a_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[17:2] == 16'd0)
    else $error("key word set without key_valid");

  a_submap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[18] |-> m_axis_tdata[23:19] == 5'd0)
    else $error("submap number set without switch_valid");

  // Both results of one key event agree on handled and follow at once.
  a_pair_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tdata[0] == $past(m_axis_tdata[0]))
    else $error("results of one item disagree");

endmodule

bind keyboard_layout_translator_top klt_checker u_klt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ test/keyboard_layout_translator_checker.sv @@
`default_nettype none

module keyboard_layout_translator_checker
  import klt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [6:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [23:0] m_axis_tdata,
  input  wire logic        m_axis_tlast,
  output int               fails_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LAYOUT_WORDS = 89 * 12;

  typedef struct packed {
    logic        handled;
    logic        key_valid;
    logic [15:0] key_word;
    logic        switch_valid;
    logic [4:0]  submap;
    logic        last;
  } key_result_t;

  logic [15:0] layout_mem [LAYOUT_WORDS];
  logic [15:0] plane_mem  [32];
  logic [7:0]  dia_mem    [2048];
  logic [7:0]  dead_pend;
  logic [7:0]  ukey_bits;
  logic        enable_q;
  logic [3:0]  planes_q;
  logic [6:0]  lock_q;
  logic [5:0]  deads_q;

  logic [15:0] key_words [2];
  int          nwords;
  logic        sw_hit;
  logic [4:0]  sw_num;

  key_result_t expected_keys [$];
  int          fails;

  assign fails_o   = fails;
  assign pending_o = expected_keys.size();

  function automatic logic [7:0] dia_rd(int unsigned a);
    return a < 2048 ? dia_mem[a] : 8'h00;
  endfunction

  // Byte offset of dead-key subtable n: each holds default, length and pairs.
  function automatic int unsigned subtable_at(int unsigned n);
    int unsigned s;
    s = 0;
    for (int unsigned i = 0; i < n; i++) s += dia_rd(s + 1) * 2 + 2;
    return s;
  endfunction

  function automatic void push_word(logic [15:0] w);
    if (nwords < 2) begin
      key_words[nwords] = w;
      nwords++;
    end
  endfunction

  function automatic bit apply_entry(logic [7:0] key, logic [15:0] e, bit cmd, bit pair);
    int unsigned c, n, s, len;
    c = e[7:0];
    if (cmd) begin
      if (c >= DEAD_LO && c < DEAD_HI) begin
        dead_pend = 8'(c);
        if (c >= deads_q + 200) dead_pend = 0;
        return 1;
      end
      if (c >= SW_LO && c < SW_HI) begin
        sw_hit = 1;
        sw_num = 5'(c - SW_BASE);
        return 1;
      end
      if (c >= UOFF_LO && c < UON_LO) begin
        ukey_bits &= ~(8'd1 << (c - UOFF_LO));
        return 1;
      end
      if (c >= UON_LO && c < UON_HI) begin
        ukey_bits |= 8'd1 << (c - UON_LO);
        return 1;
      end
      return c == NOP_CMD;
    end
    if (dead_pend > 0) begin
      n = dead_pend >= 200 ? dead_pend - 200 : 0;
      if (dead_pend < 200 || n >= deads_q) begin
        dead_pend = 0;
      end else begin
        s = subtable_at(n);
        len = dia_rd(s + 1);
        s += 2;
        dead_pend = 0;
        for (int unsigned i = 0; i < len; i++) begin
          if (dia_rd(s + i * 2) == e[7:0]) begin
            push_word({key, dia_rd(s + i * 2 + 1)});
            return 1;
          end
        end
        push_word({key, dia_rd(s - 2)});
      end
    end
    if (pair) push_word(e);
    else push_word({key, e[7:0]});
    return 1;
  endfunction

  function automatic bit translate_key(logic [7:0] key, logic [7:0] f1, logic [7:0] f2,
                                       logic [7:0] f3);
    int unsigned base, page, np;
    logic [15:0] kflags, cbits, e, cur, req, forb, ureq, uforb;
    bit sh;
    if (key > 88 || !enable_q) return 0;
    base   = key * 12;
    kflags = layout_mem[base + 11];
    cbits  = layout_mem[base + 10];
    if (((f1[6:0] & lock_q & LOCK_FILTER) == 0) && !f3[1]) begin
      sh   = (f1[1] | f1[0]) ^ (kflags[6] & f1[6]);
      page = sh ? 1 : 0;
      e    = layout_mem[base + page];
      if (e != 0 && apply_entry(key, e, cbits[page], kflags[7])) return 1;
    end
    cur = {3'b000, f3[1], f3[3:2], f2[1:0], 1'b0, f1[6:0]};
    if (f1[1:0] != 0) cur[14] = 1'b1;
    np = planes_q > 8 ? 8 : planes_q;
    for (int unsigned p = 0; p < np; p++) begin
      req   = plane_mem[p * 4];
      forb  = plane_mem[p * 4 + 1];
      ureq  = plane_mem[p * 4 + 2];
      uforb = plane_mem[p * 4 + 3];
      if ((cur & req) == req && ({8'h00, ukey_bits} & ureq) == ureq &&
          (cur & forb) == 0 && ({8'h00, ukey_bits} & uforb) == 0) begin
        e = layout_mem[base + 2 + p];
        if (e == 0) break;
        if (apply_entry(key, e, cbits[p + 2], kflags[7])) return 1;
      end
    end
    if (dead_pend > 0) begin
      case (key)
        8'h1d, 8'h2a, 8'h36, 8'h38, 8'h3a, 8'h45, 8'h46: ;
        default: begin
          if (dead_pend >= deads_q + 200) begin
            dead_pend = 0;
            return 1;
          end
          push_word({key, dia_rd(subtable_at(dead_pend - 200))});
          dead_pend = 0;
        end
      endcase
    end
    return 0;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fails++;
    end
  endtask

  // Everything is sampled at the rising edge, before any nonblocking update lands.
  always @(posedge clk_i or negedge rst_ni) begin
    key_result_t r, got;
    bit h;
    int cnt;
    logic [15:0] wd;
    logic [10:0] wi;
    if (!rst_ni) begin
      for (int i = 0; i < LAYOUT_WORDS; i++) layout_mem[i] = '0;
      for (int p = 0; p < 8; p++) begin
        plane_mem[p * 4]     = 16'h0000;
        plane_mem[p * 4 + 1] = 16'hffff;
        plane_mem[p * 4 + 2] = 16'h0000;
        plane_mem[p * 4 + 3] = 16'hffff;
      end
      dead_pend = 0;
      ukey_bits = 0;
      enable_q  = 0;
      planes_q  = 0;
      lock_q    = 7'd15;
      deads_q   = 0;
      fails     = 0;
      expected_keys.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ENABLE: enable_q = cfg_data_i[0];
          REG_PLANES: planes_q = cfg_data_i[3:0];
          REG_LOCK:   lock_q   = cfg_data_i[6:0];
          REG_DEADS:  deads_q  = cfg_data_i[5:0];
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        wi = s_axis_tdata[42:32];
        wd = s_axis_tdata[58:43];
        case (s_axis_tuser)
          OP_LAYOUT: if (wi < LAYOUT_WORDS) layout_mem[wi] = wd;
          OP_PLANE:  if (wi < 32) plane_mem[wi] = wd;
          OP_DIA:    dia_mem[wi] = wd[7:0];
          default: begin
            nwords = 0;
            sw_hit = 0;
            sw_num = 0;
            h = translate_key(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                              s_axis_tdata[31:24]);
            cnt = nwords > 0 ? nwords : 1;
            for (int k = 0; k < cnt; k++) begin
              r.handled      = h;
              r.key_valid    = k < nwords;
              r.key_word     = k < nwords ? key_words[k] : 16'h0;
              r.switch_valid = sw_hit;
              r.submap       = sw_hit ? sw_num : 5'd0;
              r.last         = k == cnt - 1;
              expected_keys  = {expected_keys, r};
            end
          end
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[17:2], m_axis_tdata[18],
               m_axis_tdata[23:19], m_axis_tlast};
        if (expected_keys.size() == 0) begin
          $error("result item with nothing expected: %h", got);
          fails++;
        end else begin
          r = expected_keys.pop_front();
          check_field("handled", r.handled, got.handled);
          check_field("key_valid", r.key_valid, got.key_valid);
          check_field("key_word", r.key_word, got.key_word);
          check_field("switch_valid", r.switch_valid, got.switch_valid);
          check_field("submap_number", r.submap, got.submap);
          check_field("last", r.last, got.last);
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ test/keyboard_layout_translator_top_test.sv @@
`default_nettype none

module keyboard_layout_translator_top_test;
  import klt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any handshake before the run is declared hung. The limit
  // must cover the clearing pass after reset and a long diacritic walk.
  localparam int HANG_LIMIT = 20000;
  // Quiet time allowed for the block to settle before a register write and at the end.
  localparam int SETTLE_CYCLES = 400;
  localparam int KEYS_PER_PHASE = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [6:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: scan_code, shift_flags, shift_flags_ext, kbd_status_flags,
  // write_index, write_data, zero above (lowest first).
  logic [63:0] s_axis_tdata = '0;
  // tuser: operation.
  logic [1:0]  s_axis_tuser = OP_KEY;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: handled, key_valid, key_word, switch_valid, submap_number.
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  int fails;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  // Where each dead-key subtable starts and how many pairs it holds.
  int unsigned sub_start [35];
  int unsigned sub_len   [35];

  keyboard_layout_translator_top dut (.*);

  keyboard_layout_translator_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .fails_o(fails), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The receiver stalls at random with the probability of the current phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a run that stops moving items in either direction is a failure.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item and holds it until the block takes it. The valid is left
  // high afterwards so that back-to-back items follow without a gap.
  task automatic send_item(logic [1:0] op, logic [7:0] scan, logic [7:0] f1, logic [7:0] f2,
                           logic [7:0] f3, logic [10:0] widx, logic [15:0] wdat);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, wdat, widx, f3, f2, f1, scan};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_key(logic [7:0] scan, logic [7:0] f1, logic [7:0] f2, logic [7:0] f3);
    send_item(OP_KEY, scan, f1, f2, f3, 11'($urandom), 16'($urandom));
  endtask

  task automatic send_write(logic [1:0] op, logic [10:0] widx, logic [15:0] wdat);
    send_item(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), widx, wdat);
  endtask

  // Registers change only once the block has handed over every result and
  // has had time to finish any write still in hand.
  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Characters that the dead-key subtables know, so that combinations are common.
  function automatic logic [7:0] some_char();
    logic [7:0] vowels [4] = '{8'h61, 8'h65, 8'h6f, 8'h75};
    return ($urandom_range(2) == 0) ? 8'($urandom) : vowels[$urandom_range(3)];
  endfunction

  function automatic logic [7:0] some_command();
    case ($urandom_range(5))
      0: return DEAD_LO + 8'($urandom_range(40));
      1: return SW_LO + 8'($urandom_range(19));
      2: return UOFF_LO + 8'($urandom_range(7));
      3: return UON_LO + 8'($urandom_range(7));
      4: return NOP_CMD;
      default: return 8'($urandom);
    endcase
  endfunction

  // Rewrites a default or a pair byte of one subtable; the length bytes stay,
  // so every walk keeps to the bytes that have been written.
  task automatic random_dia_write();
    int unsigned t;
    int unsigned off;
    t   = $urandom_range(34);
    off = $urandom_range(2 * sub_len[t] + 1);
    if (off == 1) off = 0;
    send_write(OP_DIA, 11'(sub_start[t] + off), {8'($urandom), some_char()});
  endtask

  // The layout words of one key; page 10 holds the command bits, page 11 the key flags.
  task automatic load_key(int key);
    logic [15:0] cbits;
    logic [15:0] e;
    cbits = 16'($urandom & $urandom) & 16'h03ff;
    for (int p = 0; p < 10; p++) begin
      if ($urandom_range(4) == 0) e = 16'h0;
      else if (cbits[p]) e = {8'($urandom), some_command()};
      else e = {8'($urandom), some_char()};
      send_write(OP_LAYOUT, 11'(key * 12 + p), e);
    end
    send_write(OP_LAYOUT, 11'(key * 12 + 10), cbits);
    send_write(OP_LAYOUT, 11'(key * 12 + 11), 16'($urandom));
  endtask

  // Key events are mostly on loaded scan codes, half of them with flag bytes that leave
  // the normal and shift pages reachable; a few use wild scan codes.
  task automatic random_key();
    logic [7:0] scan;
    logic [7:0] f1;
    if ($urandom_range(9) == 0) scan = 8'($urandom);
    else if ($urandom_range(1) == 0) scan = 8'(6 * $urandom_range(14));
    else scan = 8'($urandom_range(88));
    f1   = ($urandom_range(1) == 0) ? (8'($urandom) & 8'h43) : 8'($urandom);
    send_key(scan, f1, 8'($urandom), ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00);
  endtask

  task automatic random_phase(int idle, int stall);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < KEYS_PER_PHASE; i++) begin
      case ($urandom_range(19))
        0: send_write(OP_LAYOUT, ($urandom_range(9) == 0) ? 11'($urandom) :
                      11'($urandom_range(1067)), 16'($urandom));
        1: send_write(OP_PLANE, ($urandom_range(4) == 0) ? 11'($urandom) :
                      11'($urandom_range(31)), 16'($urandom & $urandom));
        2: random_dia_write();
        default: random_key();
      endcase
    end
  endtask

  initial begin
    logic [7:0] dia_image [2048];
    int unsigned s;
    int unsigned len;

    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(REG_ENABLE, 7'd1);
    write_reg(REG_PLANES, 7'd3);
    write_reg(REG_LOCK, 7'd15);
    write_reg(REG_DEADS, 7'd35);

    // The diacritic bytes have no reset value, so the 35 short subtables at
    // the front (default, length, pairs) are written and nothing reads beyond.
    for (int i = 0; i < 2048; i++) dia_image[i] = 8'($urandom);
    s = 0;
    for (int t = 0; t < 35; t++) begin
      len = $urandom_range(1, 4);
      sub_start[t] = s;
      sub_len[t]   = len;
      dia_image[s + 1] = 8'(len);
      for (int k = 0; k < len; k++) dia_image[s + 2 + 2 * k] = some_char();
      s += 2 + 2 * len;
    end
    for (int i = 0; i < s; i++) send_write(OP_DIA, 11'(i), {8'($urandom), dia_image[i]});

    for (int p = 0; p < 8; p++) begin
      send_write(OP_PLANE, 11'(p * 4), 16'($urandom & $urandom) & 16'h507f);
      send_write(OP_PLANE, 11'(p * 4 + 1), 16'($urandom & $urandom & $urandom) & 16'h5f7f);
      send_write(OP_PLANE, 11'(p * 4 + 2), 16'($urandom & $urandom) & 16'h00ff);
      send_write(OP_PLANE, 11'(p * 4 + 3), 16'($urandom & $urandom & $urandom) & 16'h00ff);
    end
    // Every sixth scan code gets a full set of pages; the rest stay cleared.
    for (int k = 0; k <= 88; k += 6) load_key(k);

    // Directed part: a dead key on scan 0x10 followed by a combining character, the
    // dead key again with a modifier that leaves it pending and an unmapped key; then
    // a switch, keys at and beyond the scan range, and a key with the layout off.
    send_write(OP_LAYOUT, 11'(16 * 12 + 0), {8'h00, DEAD_LO});
    send_write(OP_LAYOUT, 11'(16 * 12 + 10), 16'h0001);
    send_write(OP_LAYOUT, 11'(16 * 12 + 11), 16'h0000);
    send_write(OP_LAYOUT, 11'(17 * 12 + 0), {8'h00, dia_image[2]});
    send_write(OP_LAYOUT, 11'(17 * 12 + 10), 16'h0000);
    send_write(OP_LAYOUT, 11'(18 * 12 + 0), 16'h0000);
    send_write(OP_LAYOUT, 11'(18 * 12 + 10), 16'h0000);
    send_write(OP_LAYOUT, 11'(19 * 12 + 0), {8'h00, SW_LO});
    send_write(OP_LAYOUT, 11'(19 * 12 + 1), {8'h00, SW_HI - 8'd1});
    send_write(OP_LAYOUT, 11'(19 * 12 + 10), 16'h0003);
    send_key(8'h10, 8'h00, 8'h00, 8'h00);
    send_key(8'h11, 8'h00, 8'h00, 8'h00);
    send_key(8'h10, 8'h00, 8'h00, 8'h00);
    send_key(8'h1d, 8'h04, 8'h00, 8'h00);
    send_key(8'h12, 8'h00, 8'h00, 8'h00);
    send_key(8'h13, 8'h00, 8'h00, 8'h00);
    send_key(8'h13, 8'h01, 8'h00, 8'h00);
    send_key(8'h00, 8'h00, 8'h00, 8'h00);
    send_key(8'd88, 8'hff, 8'hff, 8'hff);
    send_key(8'd89, 8'h00, 8'h00, 8'h00);
    send_key(8'hff, 8'hff, 8'hff, 8'hff);
    send_key(8'h20, 8'h00, 8'h03, 8'h0e);
    write_reg(REG_ENABLE, 7'd0);
    send_key(8'h11, 8'h00, 8'h00, 8'h00);
    write_reg(REG_ENABLE, 7'd1);

    // Random part over the four handshake regimes, with the registers swept
    // through their extremes between phases.
    random_phase(0, 0);
    write_reg(REG_PLANES, 7'd15);
    write_reg(REG_LOCK, 7'd0);
    write_reg(REG_DEADS, 7'd0);
    random_phase(50, 0);
    write_reg(REG_PLANES, 7'd8);
    write_reg(REG_LOCK, 7'd127);
    write_reg(REG_DEADS, 7'd63);
    random_phase(0, 50);
    write_reg(REG_PLANES, 7'd0);
    write_reg(REG_LOCK, 7'd15);
    write_reg(REG_DEADS, 7'd3);
    random_phase(16, 16);
    write_reg(REG_PLANES, 7'd5);
    write_reg(REG_DEADS, 7'd35);
    random_phase($urandom_range(30), $urandom_range(30));

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
